// ===== src/rlt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared types and constants for the region lock table.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int COORD_W  = 16;
    localparam int HANDLE_W = 16;
    localparam int OWNER_W  = 8;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [HANDLE_W-1:0] HANDLE_FIRST = HANDLE_W'(1);
    localparam logic [HANDLE_W-1:0] HANDLE_LAST  = {HANDLE_W{1'b1}};

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_CONFLICT = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic                cmd;
        logic [COORD_W-1:0]  x_origin;
        logic [COORD_W-1:0]  y_origin;
        logic [COORD_W-1:0]  span_x;
        logic [COORD_W-1:0]  span_y;
        logic                is_write;
        logic [OWNER_W-1:0]  owner;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic                write;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  w;
        logic [COORD_W-1:0]  h;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic             clr_en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } store_cmd_t;

    typedef struct packed {
        logic overlap;
        logic key_match;
    } match_t;

endpackage
`default_nettype wire

// ===== src/rlt_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_req_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface rlt_req_if;
    import rlt_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [COORD_W-1:0]  x_origin;
    logic [COORD_W-1:0]  y_origin;
    logic [COORD_W-1:0]  span_x;
    logic [COORD_W-1:0]  span_y;
    logic                is_write;
    logic [OWNER_W-1:0]  owner;
    logic [HANDLE_W-1:0] handle_in;

    modport source (
        output valid, cmd, x_origin, y_origin, span_x, span_y, is_write, owner,
               handle_in,
        input  ready
    );

    modport sink (
        input  valid, cmd, x_origin, y_origin, span_x, span_y, is_write, owner,
               handle_in,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/rlt_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface rlt_rsp_if;
    import rlt_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;

    modport source (
        output valid, status, handle_out,
        input  ready
    );

    modport sink (
        input  valid, status, handle_out,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/rlt_entry_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_entry_store
// Lock entry memory with registered read and per-entry valid flags.
// ----------------------------------------------------------------------------
module rlt_entry_store (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [rlt_pkg::IDX_W-1:0] rd_addr,
    input  wire rlt_pkg::store_cmd_t     store_cmd,
    output rlt_pkg::entry_t              rd_entry,
    output logic                         rd_valid
);
    import rlt_pkg::*;

    entry_t           mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    entry_t           rd_entry_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (store_cmd.wr_en)
        begin
            mem[store_cmd.idx] <= store_cmd.data;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_cmd.wr_en)
            begin
                valid_reg[store_cmd.idx] <= 1'b1;
            end
            else if (store_cmd.clr_en)
            begin
                valid_reg[store_cmd.idx] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;
endmodule
`default_nettype wire

// ===== src/rlt_match_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_match_unit
// Compare unit shared by all scan steps: region overlap and handle/owner key.
// ----------------------------------------------------------------------------
module rlt_match_unit (
    input  wire rlt_pkg::req_t   req,
    input  wire rlt_pkg::entry_t entry,
    output rlt_pkg::match_t      match
);
    import rlt_pkg::*;

    logic [COORD_W:0] e_x_end;
    logic [COORD_W:0] e_y_end;
    logic [COORD_W:0] r_x_end;
    logic [COORD_W:0] r_y_end;
    logic             apart_x;
    logic             apart_y;

    always_comb
    begin
        e_x_end = {1'b0, entry.x} + {1'b0, entry.w};
        e_y_end = {1'b0, entry.y} + {1'b0, entry.h};
        r_x_end = {1'b0, req.x_origin} + {1'b0, req.span_x};
        r_y_end = {1'b0, req.y_origin} + {1'b0, req.span_y};
        // closed ranges: touching edges still overlap
        apart_x = (e_x_end < {1'b0, req.x_origin}) || (r_x_end < {1'b0, entry.x});
        apart_y = (e_y_end < {1'b0, req.y_origin}) || (r_y_end < {1'b0, entry.y});
        match.overlap   = !apart_x && !apart_y;
        match.key_match = (entry.handle == req.handle_in) && (entry.owner == req.owner);
    end
endmodule
`default_nettype wire

// ===== src/rlt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlt_ctrl
// Sequencer: latches a request, scans every entry, commits the result.
// ----------------------------------------------------------------------------
module rlt_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rlt_req_if.sink                        req,
    rlt_rsp_if.source                      rsp,
    output rlt_pkg::req_t                  cur_req,
    output logic [rlt_pkg::IDX_W-1:0]      rd_addr,
    output rlt_pkg::store_cmd_t            store_cmd,
    input  wire rlt_pkg::entry_t           rd_entry,
    input  wire logic                      rd_valid,
    input  wire rlt_pkg::match_t           match
);
    import rlt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t              state_reg,       state_next;
    req_t                req_reg,         req_next;
    logic [IDX_W-1:0]    scan_reg,        scan_next;
    logic                clash_reg,       clash_next;
    logic                free_found_reg,  free_found_next;
    logic [IDX_W-1:0]    free_idx_reg,    free_idx_next;
    logic                hit_reg,         hit_next;
    logic [IDX_W-1:0]    hit_idx_reg,     hit_idx_next;
    logic [HANDLE_W-1:0] next_handle_reg, next_handle_next;
    logic                out_valid_reg,   out_valid_next;
    status_t             out_status_reg,  out_status_next;
    logic [HANDLE_W-1:0] out_handle_reg,  out_handle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_handle_reg <= HANDLE_FIRST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_handle_reg <= next_handle_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        scan_reg       <= scan_next;
        clash_reg      <= clash_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        scan_next        = scan_reg;
        clash_next       = clash_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        next_handle_next = next_handle_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        req.ready        = 1'b0;
        rd_addr          = '0;
        store_cmd.wr_en  = 1'b0;
        store_cmd.clr_en = 1'b0;
        store_cmd.idx    = free_idx_reg;
        store_cmd.data.handle = next_handle_reg;
        store_cmd.data.owner  = req_reg.owner;
        store_cmd.data.write  = req_reg.is_write;
        store_cmd.data.x      = req_reg.x_origin;
        store_cmd.data.y      = req_reg.y_origin;
        store_cmd.data.w      = req_reg.span_x;
        store_cmd.data.h      = req_reg.span_y;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    req_next.cmd       = req.cmd;
                    req_next.x_origin  = req.x_origin;
                    req_next.y_origin  = req.y_origin;
                    req_next.span_x    = req.span_x;
                    req_next.span_y    = req.span_y;
                    req_next.is_write  = req.is_write;
                    req_next.owner     = req.owner;
                    req_next.handle_in = req.handle_in;
                    scan_next          = '0;
                    clash_next         = 1'b0;
                    free_found_next    = 1'b0;
                    hit_next           = 1'b0;
                    state_next         = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr = scan_reg + IDX_W'(1);
                if (req_reg.cmd == CMD_ACQUIRE)
                begin
                    if (rd_valid)
                    begin
                        if ((req_reg.is_write || rd_entry.write) && match.overlap)
                        begin
                            clash_next = 1'b1;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_reg;
                    end
                end
                else if (rd_valid && match.key_match && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_reg;
                end
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = '0;
                    state_next      = S_IDLE;
                    if (req_reg.cmd == CMD_ACQUIRE)
                    begin
                        if (clash_reg)
                        begin
                            out_status_next = ST_CONFLICT;
                        end
                        else if (!free_found_reg)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            out_status_next = ST_GRANTED;
                            out_handle_next = next_handle_reg;
                            store_cmd.wr_en = 1'b1;
                            next_handle_next = (next_handle_reg == HANDLE_LAST) ?
                                HANDLE_FIRST : next_handle_reg + HANDLE_W'(1);
                        end
                    end
                    else if (hit_reg)
                    begin
                        out_status_next  = ST_RELEASED;
                        store_cmd.clr_en = 1'b1;
                        store_cmd.idx    = hit_idx_reg;
                    end
                    else
                    begin
                        out_status_next = ST_NOTFOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cur_req        = req_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.handle_out = out_handle_reg;
endmodule
`default_nettype wire

// ===== src/region_lock_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// region_lock_table
// Reader/writer rectangular region lock table with handle-based release.
// ----------------------------------------------------------------------------
// The request is accepted in the idle state and entry 0 is read at the accepting
// edge; the scan then steps through every entry and the commit state registers
// the result word.
// A new request is taken only once the table is back in idle after the commit of
// the last one. A result word still held stalls the commit.
// Reset: all entries free, next handle 1, no clearing pass needed.
// ----------------------------------------------------------------------------
module region_lock_table (
    input  wire logic clk,
    input  wire logic rst_n,
    rlt_req_if.sink   req,
    rlt_rsp_if.source rsp
);
    import rlt_pkg::*;

    req_t             cur_req;
    logic [IDX_W-1:0] rd_addr;
    store_cmd_t       store_cmd;
    entry_t           rd_entry;
    logic             rd_valid;
    match_t           match;

    rlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cur_req   (cur_req),
        .rd_addr   (rd_addr),
        .store_cmd (store_cmd),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid),
        .match     (match)
    );

    rlt_entry_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .store_cmd (store_cmd),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid)
    );

    rlt_match_unit u_match (
        .req   (cur_req),
        .entry (rd_entry),
        .match (match)
    );
endmodule
`default_nettype wire

// ===== sim/region_lock_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_lock_table_tb
// Self-checking bench for the region lock table. Request words go in through
// the request channel. A scoreboard keeps its own copy of the lock table and
// predicts the status and handle of every reply. It checks each reply word
// against the oldest prediction. The stimulus is a directed opening, then
// random acquire/release traffic under four idle/stall mixes, then a closing
// pass that releases every lock still held.
// ----------------------------------------------------------------------------
module region_lock_table_tb;
    import rlt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    class lock_table_scoreboard;
        typedef struct packed {
            status_t             status;
            logic [HANDLE_W-1:0] handle;
        } reply_t;

        bit                  live       [ENTRIES];
        logic [HANDLE_W-1:0] lock_handle[ENTRIES];
        logic [OWNER_W-1:0]  lock_owner [ENTRIES];
        bit                  lock_write [ENTRIES];
        logic [COORD_W-1:0]  lock_x     [ENTRIES];
        logic [COORD_W-1:0]  lock_y     [ENTRIES];
        logic [COORD_W-1:0]  lock_w     [ENTRIES];
        logic [COORD_W-1:0]  lock_h     [ENTRIES];
        logic [HANDLE_W-1:0] next_handle;
        reply_t              replies_due[$];
        int                  errors;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                live[i] = 1'b0;
            end
            next_handle = HANDLE_FIRST;
            errors      = 0;
        endfunction

        // closed ranges [a, a+alen] and [b, b+blen], sums at 17 bits
        function bit ranges_apart(input logic [COORD_W:0] a, input logic [COORD_W:0] alen,
                                  input logic [COORD_W:0] b, input logic [COORD_W:0] blen);
            return (a + alen < b) || (b + blen < a);
        endfunction

        function void note_request(input req_t w);
            reply_t r;
            int     free_slot;
            bit     clash;
            bit     found;
            r.status  = ST_NOTFOUND;
            r.handle  = '0;
            free_slot = -1;
            clash     = 1'b0;
            found     = 1'b0;
            if (w.cmd == CMD_ACQUIRE)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (live[i])
                    begin
                        if ((w.is_write || lock_write[i]) &&
                            !ranges_apart(lock_x[i], lock_w[i], w.x_origin, w.span_x) &&
                            !ranges_apart(lock_y[i], lock_h[i], w.y_origin, w.span_y))
                            clash = 1'b1;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (clash)
                    r.status = ST_CONFLICT;
                else if (free_slot < 0)
                    r.status = ST_FULL;
                else
                begin
                    live[free_slot]        = 1'b1;
                    lock_handle[free_slot] = next_handle;
                    lock_owner[free_slot]  = w.owner;
                    lock_write[free_slot]  = w.is_write;
                    lock_x[free_slot]      = w.x_origin;
                    lock_y[free_slot]      = w.y_origin;
                    lock_w[free_slot]      = w.span_x;
                    lock_h[free_slot]      = w.span_y;
                    r.status               = ST_GRANTED;
                    r.handle               = next_handle;
                    next_handle = (next_handle == HANDLE_LAST) ? HANDLE_FIRST :
                                  next_handle + HANDLE_W'(1);
                end
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!found && live[i] && lock_handle[i] == w.handle_in &&
                        lock_owner[i] == w.owner)
                    begin
                        live[i]  = 1'b0;
                        r.status = ST_RELEASED;
                        found    = 1'b1;
                    end
                end
            end
            replies_due.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 100)
                $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_reply(input status_t st, input logic [HANDLE_W-1:0] hnd);
            reply_t due;
            if (replies_due.size() == 0)
            begin
                report_mismatch($sformatf("reply with none pending: status=%0d handle=%0d",
                                          st, hnd));
                return;
            end
            due = replies_due.pop_front();
            if (st !== due.status)
                report_mismatch($sformatf("status %0d, predicted %0d", st, due.status));
            if (hnd !== due.handle)
                report_mismatch($sformatf("handle %0d, predicted %0d", hnd, due.handle));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   quiet_cycles;

    lock_table_scoreboard sb;

    rlt_req_if req_ch ();
    rlt_rsp_if rsp_ch ();

    region_lock_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_reply(rsp_ch.status, rsp_ch.handle_out);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // valid stays high between back-to-back words; it drops only for a gap
    task automatic send_word(input req_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= w.cmd;
        req_ch.x_origin  <= w.x_origin;
        req_ch.y_origin  <= w.y_origin;
        req_ch.span_x    <= w.span_x;
        req_ch.span_y    <= w.span_y;
        req_ch.is_write  <= w.is_write;
        req_ch.owner     <= w.owner;
        req_ch.handle_in <= w.handle_in;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sb.note_request(w);
    endtask

    task automatic acquire_lock(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                                input logic wr, input logic [OWNER_W-1:0] who);
        req_t r;
        r.cmd       = CMD_ACQUIRE;
        r.x_origin  = x;
        r.y_origin  = y;
        r.span_x    = w;
        r.span_y    = h;
        r.is_write  = wr;
        r.owner     = who;
        r.handle_in = HANDLE_W'($urandom_range(0, 65535));
        send_word(r);
    endtask

    task automatic release_lock(input logic [HANDLE_W-1:0] hnd, input logic [OWNER_W-1:0] who);
        req_t r;
        r.cmd       = CMD_RELEASE;
        r.x_origin  = COORD_W'($urandom_range(0, 65535));
        r.y_origin  = COORD_W'($urandom_range(0, 65535));
        r.span_x    = COORD_W'($urandom_range(0, 65535));
        r.span_y    = COORD_W'($urandom_range(0, 65535));
        r.is_write  = 1'($urandom_range(0, 1));
        r.owner     = who;
        r.handle_in = hnd;
        send_word(r);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return COORD_W'($urandom_range(0, 300));
        else if (sel == 7)
            return $urandom_range(0, 1) ? {COORD_W{1'b1}} : '0;
        else
            return COORD_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [COORD_W-1:0] pick_span();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return COORD_W'($urandom_range(0, 40));
        else if (sel == 6)
            return '0;
        else if (sel == 7)
            return {COORD_W{1'b1}};
        else
            return COORD_W'($urandom_range(0, 65535));
    endfunction

    task automatic random_word();
        int live_idx[$];
        int acq_pct;
        int sel;
        int k;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sb.live[i])
                live_idx.push_back(i);
        end
        if (live_idx.size() == 0)
            acq_pct = 85;
        else if (live_idx.size() >= ENTRIES)
            acq_pct = 35;
        else
            acq_pct = 60;
        if ($urandom_range(99) < acq_pct)
        begin
            acquire_lock(pick_coord(), pick_coord(), pick_span(), pick_span(),
                         $urandom_range(99) < 30, OWNER_W'($urandom_range(0, 255)));
        end
        else
        begin
            sel = $urandom_range(0, 19);
            if (live_idx.size() != 0 && sel < 16)
            begin
                k = live_idx[$urandom_range(0, live_idx.size() - 1)];
                if (sel < 14)
                    release_lock(sb.lock_handle[k], sb.lock_owner[k]);
                else
                    release_lock(sb.lock_handle[k],
                                 sb.lock_owner[k] ^ OWNER_W'($urandom_range(1, 255)));
            end
            else if (sel == 16)
                release_lock('0, OWNER_W'($urandom_range(0, 255)));
            else
                release_lock(HANDLE_W'($urandom_range(0, 65535)),
                             OWNER_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic release_all();
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sb.live[i])
                release_lock(sb.lock_handle[i], sb.lock_owner[i]);
        end
    endtask

    task automatic directed_words();
        logic [HANDLE_W-1:0] wr_handle;
        release_lock('0, '0);
        acquire_lock('0, '0, '0, '0, 1'b1, 8'h00);
        acquire_lock('0, '0, '0, '0, 1'b0, 8'hFF);
        acquire_lock(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
        acquire_lock(16'd1, '0, '0, '0, 1'b0, 8'h22);
        wr_handle = sb.next_handle;
        acquire_lock(16'd100, 16'd100, 16'd10, 16'd10, 1'b1, 8'h11);
        // edges touching the write lock on both axes
        acquire_lock(16'd110, 16'd50, '0, 16'd50, 1'b0, 8'h33);
        acquire_lock(16'd111, 16'd50, 16'd5, 16'd50, 1'b0, 8'h33);
        acquire_lock(16'd90, 16'd111, 16'd20, '0, 1'b0, 8'h44);
        acquire_lock(16'd105, 16'd105, 16'd1, 16'd1, 1'b0, 8'h44);
        acquire_lock(16'd111, 16'd50, 16'd5, 16'd50, 1'b0, 8'h55);
        acquire_lock(16'd113, 16'd60, '0, '0, 1'b1, 8'h55);
        for (int i = 0; i < 9; i++)
        begin
            acquire_lock(16'd1000 + 16'(i * 10), 16'd1000, '0, '0, 1'b0, 8'(i));
        end
        acquire_lock(16'd2000, 16'd2000, '0, '0, 1'b0, 8'h66);
        // conflict takes precedence over full
        acquire_lock(16'd100, 16'd100, '0, '0, 1'b1, 8'h66);
        release_lock(wr_handle, 8'h12);
        release_lock(wr_handle, 8'h11);
        release_lock(wr_handle, 8'h11);
    endtask

    initial
    begin
        int send_mix[4];
        int stall_mix[4];
        send_mix  = '{0, 52, 0, 28};
        stall_mix = '{0, 0, 52, 28};
        sb               = new();
        clk              = 1'b0;
        rst_n            = 1'b0;
        quiet_cycles     = 0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        rsp_ch.ready     = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_ACQUIRE;
        req_ch.x_origin  = '0;
        req_ch.y_origin  = '0;
        req_ch.span_x    = '0;
        req_ch.span_y    = '0;
        req_ch.is_write  = 1'b0;
        req_ch.owner     = '0;
        req_ch.handle_in = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_mix[p];
            stall_pct     = stall_mix[p];
            repeat (150) random_word();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
        release_all();
        req_ch.valid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge clk);
        repeat (2 * (ENTRIES + 2)) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/rlt_pkg.sv
src/rlt_req_if.sv
src/rlt_rsp_if.sv
src/rlt_entry_store.sv
src/rlt_match_unit.sv
src/rlt_ctrl.sv
src/region_lock_table.sv
sim/region_lock_table_tb.sv
